FILE: design/cnc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coverage novelty check package
// Shared widths, verdict codes, controller states and command structures.
// ----------------------------------------------------------------------------
package cnc_pkg;

    localparam int INDEX_W  = 13;
    localparam int WORD_W   = 64;
    localparam int BYTES    = 8;
    localparam int VERDICT_W = 2;

    localparam logic [7:0] PRISTINE_BYTE = 8'hFF;

    typedef logic [VERDICT_W-1:0] verdict_t;

    localparam verdict_t VERDICT_NONE      = 2'd0;
    localparam verdict_t VERDICT_NEW_COUNT = 2'd1;
    localparam verdict_t VERDICT_NEW_EDGE  = 2'd2;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE,
        ST_EMIT
    } cnc_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic in_ready;
        logic clr_wr;
        logic upd;
        logic emit;
    } cnc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic captured;
        logic last;
        logic slot_free;
        logic clr_done;
    } cnc_sts_t;

    // True if some nonzero trace byte meets a virgin byte still at 0xFF.
    function automatic logic touches_pristine(input logic [WORD_W-1:0] t,
                                              input logic [WORD_W-1:0] v);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < BYTES; k++)
        begin
            if ((t[k*8 +: 8] != 8'h00) && (v[k*8 +: 8] == PRISTINE_BYTE))
            begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

FILE: design/cnc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coverage novelty check channels
// Valid/ready channels for trace beats in and verdict beats out.
// ----------------------------------------------------------------------------
interface cnc_in_if;
    import cnc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [INDEX_W-1:0]   word_index;
    logic [WORD_W-1:0]    trace_word;
    logic                 last_word;

    modport source (output valid, output word_index, output trace_word,
                    output last_word, input ready);
    modport sink   (input valid, input word_index, input trace_word,
                    input last_word, output ready);
endinterface

interface cnc_out_if;
    import cnc_pkg::*;

    logic     valid;
    logic     ready;
    verdict_t verdict;

    modport source (output valid, output verdict, input ready);
    modport sink   (input valid, input verdict, output ready);
endinterface

FILE: design/cnc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coverage novelty check controller
// Sequences the clearing pass, capture, write-back and verdict output.
// ----------------------------------------------------------------------------
module cnc_ctrl
    import cnc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cnc_sts_t sts,
    output cnc_cmd_t cmd
);

    cnc_state_t state_reg;
    cnc_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (sts.captured)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (sts.last && !sts.slot_free)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (sts.slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
            end
            ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
            end
            ST_UPDATE:
            begin
                cmd.upd  = 1'b1;
                cmd.emit = sts.last && sts.slot_free;
            end
            ST_EMIT:
            begin
                cmd.emit = sts.slot_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

FILE: design/cnc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coverage novelty check datapath
// Virgin map memory, captured beat, run verdict and output register.
// ----------------------------------------------------------------------------
module cnc_datapath
    import cnc_pkg::*;
#(
    parameter int MAP_WORDS = 8192
)
(
    input  logic          clk,
    input  logic          rst_n,
    cnc_in_if.sink        trace,
    cnc_out_if.source     result,
    input  cnc_cmd_t      cmd,
    output cnc_sts_t      sts
);

    localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

    logic [WORD_W-1:0] virgin_mem [MAP_WORDS];

    logic [AW-1:0]     clr_addr_reg;
    logic [AW-1:0]     clr_addr_next;
    logic [AW-1:0]     addr_reg;
    logic [WORD_W-1:0] trace_reg;
    logic [WORD_W-1:0] rd_data_reg;
    logic              last_reg;
    logic              in_range_reg;
    verdict_t          run_reg;
    verdict_t          run_next;
    verdict_t          out_verdict_reg;
    logic              out_valid_reg;
    logic              out_valid_next;

    logic              captured;
    logic              in_range;
    logic [AW-1:0]     rd_addr;
    logic              hit;
    verdict_t          run_new;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [WORD_W-1:0] wr_data;

    assign trace.ready = cmd.in_ready;
    assign captured    = trace.valid && cmd.in_ready;
    assign in_range    = 32'(trace.word_index) < 32'(MAP_WORDS);
    assign rd_addr     = AW'(trace.word_index);

    // Map word read on capture; the registered data is used in the following cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            virgin_mem[wr_addr] <= wr_data;
        end
        if (captured)
        begin
            rd_data_reg <= virgin_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (captured)
        begin
            addr_reg     <= rd_addr;
            trace_reg    <= trace.trace_word;
            last_reg     <= trace.last_word;
            in_range_reg <= in_range;
        end
        if (cmd.emit)
        begin
            out_verdict_reg <= cmd.upd ? run_new : run_reg;
        end
    end

    assign hit = in_range_reg && ((trace_reg & rd_data_reg) != '0);

    always_comb
    begin
        run_new = run_reg;
        if (hit && (run_reg != VERDICT_NEW_EDGE))
        begin
            run_new = touches_pristine(trace_reg, rd_data_reg) ? VERDICT_NEW_EDGE
                                                               : VERDICT_NEW_COUNT;
        end
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = clr_addr_reg;
        wr_data = '1;
        if (cmd.clr_wr)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.upd && hit)
        begin
            wr_en   = 1'b1;
            wr_addr = addr_reg;
            wr_data = rd_data_reg & ~trace_reg;
        end
    end

    always_comb
    begin
        run_next = run_reg;
        if (cmd.upd)
        begin
            run_next = run_new;
        end
        if (cmd.emit)
        begin
            run_next = VERDICT_NONE;
        end
    end

    assign clr_addr_next  = cmd.clr_wr ? clr_addr_reg + AW'(1) : clr_addr_reg;
    assign out_valid_next = cmd.emit ? 1'b1 : (result.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg  <= '0;
            run_reg       <= VERDICT_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clr_addr_reg  <= clr_addr_next;
            run_reg       <= run_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.verdict = out_verdict_reg;

    assign sts.captured  = captured;
    assign sts.last      = last_reg;
    assign sts.slot_free = !out_valid_reg || result.ready;
    assign sts.clr_done  = clr_addr_reg == AW'(MAP_WORDS - 1);

endmodule

FILE: design/coverage_novelty_check_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coverage novelty check top level
// Virgin coverage map with a run verdict raised by new hit-count bits.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload                               Beats
//  trace     in         word_index, trace_word, last_word     one per map word
//  result    out        verdict                               one per last word
//
// Each trace beat is accepted and its map word read from the virgin memory, then
// the word is written back and the run verdict updated; no new beat is accepted
// until that write-back is done.
// After reset a clearing pass writes all ones into every map word, one word a cycle;
// no trace beat is accepted until it ends.
// A verdict waits in an output register, so a stalled result only holds the
// block once a further last word arrives while the register is still full.
// ----------------------------------------------------------------------------
module coverage_novelty_check_top
    import cnc_pkg::*;
#(
    parameter int MAP_WORDS = 8192
)
(
    input  logic      clk,
    input  logic      rst_n,
    cnc_in_if.sink    trace,
    cnc_out_if.source result
);

    cnc_cmd_t cmd;
    cnc_sts_t sts;

    // The controller only sequences; all storage for the map sits in the
    // datapath.
    cnc_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    cnc_datapath #(
        .MAP_WORDS (MAP_WORDS)
    ) u_datapath
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .trace  (trace),
        .result (result),
        .cmd    (cmd),
        .sts    (sts)
    );

    // A captured beat is always followed by its update step in the very next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) sts.captured |=> cmd.upd)
        else $error("write-back did not follow a captured beat");

    // No beat is taken while the clearing pass still owns the write port.
    assert property (@(posedge clk) disable iff (!rst_n) cmd.clr_wr |-> !trace.ready)
        else $error("trace beat accepted during clearing pass");

    // A verdict is loaded only into a free output register.
    assert property (@(posedge clk) disable iff (!rst_n)
                     cmd.emit |-> (!result.valid || result.ready))
        else $error("verdict overwrote a pending result");

    // A verdict loaded into the output register is presented on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
                     cmd.emit |=> result.valid)
        else $error("emitted verdict not presented");

endmodule
